### rtl/core/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types, constants and code tables for the packed base store.
// ----------------------------------------------------------------------------
package pbs_pkg;

    localparam int POS_W      = 14;  // base position width
    localparam int BIT_POS_W  = 16;  // bit address of a code
    localparam int BYTE_IDX_W = 13;  // byte address of a code
    localparam int BANK_IDX_W = 12;  // byte address within one bank

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_G      = 8'h67;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    localparam logic [2:0] CODE_LIMIT_3B = 3'd5;

    localparam logic MODE_2BIT = 1'b0;
    localparam logic MODE_3BIT = 1'b1;

    typedef struct packed {
        logic       ok;
        logic [2:0] code;
    } pbs_code_t;

    // Decoded request, handed from the address decoder to the store
    typedef struct packed {
        logic                  in_range;
        logic                  straddle;
        logic                  lo_odd;    // first byte sits in the odd bank
        logic [BANK_IDX_W-1:0] even_idx;
        logic [BANK_IDX_W-1:0] odd_idx;
        logic [3:0]            shamt;     // code position in the byte pair
        pbs_code_t             wcode;
    } pbs_req_t;

    // ASCII base to code in the current mode
    function automatic pbs_code_t base_code(input logic [7:0] ch, input logic mode);
        pbs_code_t r;
        r.ok   = 1'b1;
        r.code = 3'd0;
        if (mode == MODE_3BIT)
        begin
            unique case (ch)
                CH_DOLLAR: r.code = 3'd0;
                CH_A:      r.code = 3'd1;
                CH_C:      r.code = 3'd2;
                CH_G:      r.code = 3'd3;
                CH_T:      r.code = 3'd4;
                default:   r.ok   = 1'b0;
            endcase
        end
        else
        begin
            unique case (ch)
                CH_A:    r.code = 3'd0;
                CH_C:    r.code = 3'd1;
                CH_G:    r.code = 3'd2;
                CH_T:    r.code = 3'd3;
                default: r.ok   = 1'b0;
            endcase
        end
        return r;
    endfunction

    // Code to ASCII base; unused 3-bit codes read as '*'
    function automatic logic [7:0] code_char(input logic [2:0] code, input logic mode);
        logic [7:0] ch;
        ch = CH_STAR;
        if (mode == MODE_3BIT)
        begin
            unique case (code)
                3'd0:    ch = CH_DOLLAR;
                3'd1:    ch = CH_A;
                3'd2:    ch = CH_C;
                3'd3:    ch = CH_G;
                3'd4:    ch = CH_T;
                default: ch = CH_STAR;
            endcase
        end
        else
        begin
            unique case (code[1:0])
                2'd0: ch = CH_A;
                2'd1: ch = CH_C;
                2'd2: ch = CH_G;
                2'd3: ch = CH_T;
            endcase
        end
        return ch;
    endfunction

endpackage

### rtl/core/pbs_decode.sv
// ----------------------------------------------------------------------------
// pbs_decode
// Turns a base position and character into bank addresses, pair shift,
// range check and the code to OR in.
// ----------------------------------------------------------------------------
module pbs_decode
    import pbs_pkg::*;
#(
    parameter int STORE_BYTES = 4096
)
(
    input  logic [POS_W-1:0] position,
    input  logic [7:0]       base_char,
    input  logic             mode,
    output pbs_req_t         req
);

    logic [BIT_POS_W-1:0]  pos_ext;
    logic [BIT_POS_W-1:0]  bit_pos;
    logic [BIT_POS_W-1:0]  last_bit;
    logic [2:0]            sym_w;
    logic [BYTE_IDX_W-1:0] byte_idx;
    logic [BYTE_IDX_W-1:0] last_byte;
    logic [2:0]            offset;
    logic [BYTE_IDX_W:0]   next_byte;

    // Bit address: position times symbol width
    assign pos_ext  = BIT_POS_W'(position);
    assign sym_w    = (mode == MODE_3BIT) ? 3'd3 : 3'd2;
    assign bit_pos  = (mode == MODE_3BIT) ? (pos_ext + (pos_ext << 1)) : (pos_ext << 1);
    assign last_bit = bit_pos + BIT_POS_W'(sym_w - 3'd1);

    assign byte_idx  = bit_pos[BIT_POS_W-1:3];
    assign offset    = bit_pos[2:0];
    assign last_byte = last_bit[BIT_POS_W-1:3];
    assign next_byte = (BYTE_IDX_W+1)'(byte_idx) + (BYTE_IDX_W+1)'(1);

    always_comb
    begin
        req.in_range = 32'(last_byte) < 32'(STORE_BYTES);
        req.straddle = (4'(offset) + 4'(sym_w)) > 4'd8;
        req.lo_odd   = byte_idx[0];
        // Even bank holds the first byte, or the second one when the first is odd
        req.even_idx = byte_idx[0] ? next_byte[BANK_IDX_W:1] : byte_idx[BANK_IDX_W:1];
        req.odd_idx  = byte_idx[BANK_IDX_W:1];
        req.shamt    = 4'(5'd16 - 5'(offset) - 5'(sym_w));
        req.wcode    = base_code(base_char, mode);
    end

endmodule

### rtl/core/pbs_bank.sv
// ----------------------------------------------------------------------------
// pbs_bank
// One byte bank: synchronous memory with a registered read and a bypass of
// the latest write, so a read issued on the edge of a write sees new data.
// ----------------------------------------------------------------------------
module pbs_bank
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_idx,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_idx,
    input  logic [7:0]    wr_data,
    output logic [7:0]    rd_data
);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_idx_reg;
    logic [7:0]    fwd_data_reg;

    // Memory array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
            rd_idx_reg  <= rd_idx;
        end
    end

    // Last write, kept for the bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_idx_reg  <= wr_idx;
            fwd_data_reg <= wr_data;
        end
    end

    // The bypass always holds the current contents of its entry
    assign rd_data = (fwd_valid_reg && (fwd_idx_reg == rd_idx_reg)) ? fwd_data_reg
                                                                     : rd_data_reg;

endmodule

### rtl/core/packed_base_store_unit.sv
// Reads: bank data and the request are registered at acceptance; the result at retirement.
// Throughput: one request per cycle unless a read waits on out_ready; the byte banks take
// one read and one write each cycle. Writes retire in the cycle after acceptance with
// read-modify-write on one byte bank, or both when the code straddles. Reset: mode returns
// to 2-bit; a clearing pass zeroes both banks while in_ready stays low (cfg_ready stays high).
// ----------------------------------------------------------------------------
// packed_base_store_unit
// Byte store of DNA bases packed 2 or 3 bits per base, MSB first; writes OR
// a base code in, reads return the ASCII base.
// ----------------------------------------------------------------------------
module packed_base_store_unit
    import pbs_pkg::*;
#(
    parameter int STORE_BYTES = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             symbol_width_mode,
    // request channel
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             kind,
    input  logic [POS_W-1:0] position,
    input  logic [7:0]       base_char,
    // result channel
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       base_char_out
);

    localparam int EVEN_DEPTH = (STORE_BYTES + 1) / 2;
    localparam int ODD_DEPTH  = STORE_BYTES / 2;
    localparam int BANK_AW    = (EVEN_DEPTH > 2) ? $clog2(EVEN_DEPTH) : 1;

    logic                mode_reg;
    logic                clear_reg;
    logic [BANK_AW-1:0]  clear_cnt_reg;
    logic                s_valid_reg;
    logic                s_write_reg;
    pbs_req_t            s_req_reg;
    logic                out_valid_reg;
    logic [7:0]          out_char_reg;

    pbs_req_t            req;
    logic                accept;
    logic                retire;
    logic                wr_fire;
    logic [7:0]          even_rd;
    logic [7:0]          odd_rd;
    logic                even_rd_en;
    logic                odd_rd_en;
    logic                even_wr_en;
    logic                odd_wr_en;
    logic [BANK_AW-1:0]  even_wr_idx;
    logic [BANK_AW-1:0]  odd_wr_idx;
    logic [7:0]          even_wr_data;
    logic [7:0]          odd_wr_data;
    logic [15:0]         pair;
    logic [15:0]         pair_new;
    logic [15:0]         pair_shr;
    logic [2:0]          code_mask;
    logic [2:0]          rd_code;
    logic [7:0]          rd_char;

    // Request decode
    pbs_decode #(
        .STORE_BYTES (STORE_BYTES)
    ) u_decode (
        .position  (position),
        .base_char (base_char),
        .mode      (mode_reg),
        .req       (req)
    );

    // Handshake
    assign cfg_ready = 1'b1;
    assign retire    = s_valid_reg && (s_write_reg || !out_valid_reg || out_ready);
    assign in_ready  = !clear_reg && (!s_valid_reg || retire);
    assign accept    = in_valid && in_ready;

    // Bank reads at acceptance
    assign even_rd_en = accept && req.in_range && (!req.lo_odd || req.straddle);
    assign odd_rd_en  = accept && req.in_range && (req.lo_odd || req.straddle);

    // Byte pair of the request in stage
    assign pair      = s_req_reg.lo_odd ? {odd_rd, even_rd} : {even_rd, odd_rd};
    assign pair_shr  = pair >> s_req_reg.shamt;
    assign code_mask = (mode_reg == MODE_3BIT) ? 3'b111 : 3'b011;
    assign rd_code   = pair_shr[2:0] & code_mask;
    assign rd_char   = s_req_reg.in_range ? code_char(rd_code, mode_reg) : CH_STAR;
    assign pair_new  = pair | (16'(s_req_reg.wcode.code) << s_req_reg.shamt);

    // Write-back, or zero fill while clearing
    assign wr_fire = retire && s_write_reg && s_req_reg.in_range && s_req_reg.wcode.ok;

    always_comb
    begin
        if (clear_reg)
        begin
            even_wr_en   = 1'b1;
            odd_wr_en    = 32'(clear_cnt_reg) < 32'(ODD_DEPTH);
            even_wr_idx  = clear_cnt_reg;
            odd_wr_idx   = clear_cnt_reg;
            even_wr_data = 8'd0;
            odd_wr_data  = 8'd0;
        end
        else
        begin
            even_wr_en   = wr_fire && (!s_req_reg.lo_odd || s_req_reg.straddle);
            odd_wr_en    = wr_fire && (s_req_reg.lo_odd || s_req_reg.straddle);
            even_wr_idx  = BANK_AW'(s_req_reg.even_idx);
            odd_wr_idx   = BANK_AW'(s_req_reg.odd_idx);
            even_wr_data = s_req_reg.lo_odd ? pair_new[7:0] : pair_new[15:8];
            odd_wr_data  = s_req_reg.lo_odd ? pair_new[15:8] : pair_new[7:0];
        end
    end

    // Byte banks
    pbs_bank #(
        .DEPTH (EVEN_DEPTH),
        .AW    (BANK_AW)
    ) u_bank_even (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (even_rd_en),
        .rd_idx  (BANK_AW'(req.even_idx)),
        .wr_en   (even_wr_en),
        .wr_idx  (even_wr_idx),
        .wr_data (even_wr_data),
        .rd_data (even_rd)
    );

    pbs_bank #(
        .DEPTH (ODD_DEPTH),
        .AW    (BANK_AW)
    ) u_bank_odd (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (odd_rd_en),
        .rd_idx  (BANK_AW'(req.odd_idx)),
        .wr_en   (odd_wr_en),
        .wr_idx  (odd_wr_idx),
        .wr_data (odd_wr_data),
        .rd_data (odd_rd)
    );

    // Control: mode, clearing pass, stage valid, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_2BIT;
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
            s_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= symbol_width_mode;
            end
            if (clear_reg)
            begin
                if (clear_cnt_reg == BANK_AW'(EVEN_DEPTH - 1))
                begin
                    clear_reg <= 1'b0;
                end
                clear_cnt_reg <= clear_cnt_reg + BANK_AW'(1);
            end
            if (accept)
            begin
                s_valid_reg <= 1'b1;
            end
            else if (retire)
            begin
                s_valid_reg <= 1'b0;
            end
            if (retire && !s_write_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_write_reg <= kind;
            s_req_reg   <= req;
        end
        if (retire && !s_write_reg)
        begin
            out_char_reg <= rd_char;
        end
    end

    assign out_valid     = out_valid_reg;
    assign base_char_out = out_char_reg;

endmodule
